// ===== rtl/core/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold on every rising clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/fmodf_pkg.sv =====
// package with format constants for the modf split
package fmodf_pkg;
  localparam int unsigned SpMant = 23;
  localparam int unsigned SpExp  = 8;
  localparam int unsigned DpMant = 52;
  localparam int unsigned DpExp  = 11;
endpackage

// ===== rtl/core/float_modf_split.sv =====
// top level of the floating-point modf split
// result valid rises in the cycle after an input is accepted
// throughput: one item per cycle while the output is not stalled, set by the single result register stage
// input ready follows output ready or an empty result register
// reset clears the result valid flag and propagate_nan to zero
module float_modf_split (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_bits_i,
  input  logic        is_double_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] fraction_bits_o,
  output logic [63:0] integral_bits_o
);
  logic        pnan_q;
  logic        vld_q;
  logic [63:0] fr_q, fr_d, ip_q, ip_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !vld_q || out_ready_i;

  // split for one format; widths fixed to 64 with format selected by dbl
  function automatic void split(input logic [63:0] x, input logic dbl, input logic pn,
                                output logic [63:0] fr, output logic [63:0] ip);
    logic [63:0] signbit, mmask, below, f, sign, fn;
    logic [10:0] emax, bias, ef, e, bexp;
    logic [5:0]  mb, p;
    logic        nan;
    mb      = dbl ? 6'(fmodf_pkg::DpMant) : 6'(fmodf_pkg::SpMant);
    emax    = dbl ? 11'h7ff : 11'h0ff;
    bias    = emax >> 1;
    signbit = dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    mmask   = (64'd1 << mb) - 64'd1;
    ef      = 11'((x >> mb)) & emax;
    sign    = x & signbit;
    nan     = (ef == emax) && ((x & mmask) != 64'd0);
    e       = ef - bias;
    below   = mmask >> e[5:0];
    f       = x & below;
    p       = '0;
    // priority encode the leading one of the cleared bits
    for (int i = 0; i < 52; i++) begin
      if (f[i]) p = 6'(i);
    end
    bexp = e + 11'(p) + bias - 11'(mb);
    fn   = (f << (mb - p)) & mmask;
    if (ef < bias) begin
      ip = sign; fr = x;
    end else if (e >= 11'(mb) || f == 64'd0) begin
      ip = x; fr = sign;
    end else begin
      ip = x & ~below;
      fr = sign | (64'(bexp) << mb) | fn;
    end
    if (nan && pn) begin
      ip = x; fr = x;
    end
  endfunction

  always_comb begin
    logic [63:0] x;
    x = is_double_i ? value_bits_i : {32'd0, value_bits_i[31:0]};
    split(x, is_double_i, pnan_q, fr_d, ip_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnan_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) pnan_q <= cfg_data_i;
      if (in_ready_o) vld_q <= in_valid_i;
    end
  end

  // payload register, loaded on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      fr_q <= fr_d;
      ip_q <= ip_d;
    end
  end

  assign out_valid_o     = vld_q;
  assign fraction_bits_o = fr_q;
  assign integral_bits_o = ip_q;
endmodule

// ===== rtl/core/fmodf_checker.sv =====
// port-level checker for the modf split, with bind
`include "assert_macros.svh"
module fmodf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] fraction_bits_o,
  input logic [63:0] integral_bits_o
);
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(fraction_bits_o) && $stable(integral_bits_o), "stalled result changed")
  `CHK_NEXT(a_accept_gives, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o, "accepted item gave no result")
  `CHK_ALWAYS(a_ready, clk_i, rst_ni, out_valid_o || in_ready_o, "ready low with empty output")
  `CHK_NEXT(a_no_invent, clk_i, rst_ni, !(in_valid_i && in_ready_o) && (!out_valid_o || out_ready_i), !out_valid_o, "result without item")
endmodule

bind float_modf_split fmodf_checker u_fmodf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .fraction_bits_o(fraction_bits_o), .integral_bits_o(integral_bits_o)
);

// ===== tb/float_modf_split_tb.sv =====
// testbench for the floating-point modf split: directed and random items, scoreboard check

class modf_scoreboard;
  bit          nan_mode;
  logic [63:0] exp_frac_q[$];
  logic [63:0] exp_int_q[$];
  int          errors;

  // split one value of a given format into fraction and integral part
  function automatic void split_fmt(input logic [63:0] x, input int mb, input int eb,
                                    output logic [63:0] fr, output logic [63:0] ip);
    logic [63:0] emax, bias, mmask, ef, sgn, below, f, bexp;
    int          e, p;
    bit          nan;
    emax  = (64'd1 << eb) - 1;
    bias  = emax >> 1;
    mmask = (64'd1 << mb) - 1;
    ef    = (x >> mb) & emax;
    sgn   = x & (64'd1 << (mb + eb));
    nan   = (ef == emax) && ((x & mmask) != 0);
    if (ef < bias) begin
      ip = sgn;
      fr = x;
    end else if (ef - bias >= mb) begin
      ip = x;
      fr = sgn;
    end else begin
      e     = int'(ef - bias);
      below = mmask >> e;
      f     = x & below;
      if (f == 0) begin
        ip = x;
        fr = sgn;
      end else begin
        p = 0;
        for (int i = 0; i < 64; i++) if (f[i]) p = i;
        bexp = e + p + bias - mb;
        ip   = x & ~below;
        fr   = sgn | (bexp << mb) | ((f << (mb - p)) & mmask);
      end
    end
    if (nan && nan_mode) begin
      ip = x;
      fr = x;
    end
  endfunction

  function void note_item(logic [63:0] v, logic dbl);
    logic [63:0] fr, ip;
    if (dbl) split_fmt(v, fmodf_pkg::DpMant, fmodf_pkg::DpExp, fr, ip);
    else begin
      split_fmt({32'd0, v[31:0]}, fmodf_pkg::SpMant, fmodf_pkg::SpExp, fr, ip);
      fr[63:32] = '0;
      ip[63:32] = '0;
    end
    exp_frac_q.push_back(fr);
    exp_int_q.push_back(ip);
  endfunction

  function void check_result(logic [63:0] fr, logic [63:0] ip);
    logic [63:0] efr, eip;
    if (exp_frac_q.size() == 0) begin
      $display("%0t: unexpected result frac=%h int=%h", $time, fr, ip);
      errors++;
      return;
    end
    efr = exp_frac_q.pop_front();
    eip = exp_int_q.pop_front();
    if (fr !== efr) begin
      $display("%0t: fraction expected %h actual %h", $time, efr, fr);
      errors++;
    end
    if (ip !== eip) begin
      $display("%0t: integral expected %h actual %h", $time, eip, ip);
      errors++;
    end
  endfunction
endclass

module float_modf_split_tb;
  logic        clk;
  logic        rst_n;
  logic        cfg_valid, cfg_ready, cfg_data;
  logic        in_valid, in_ready;
  logic [63:0] value_bits;
  logic        is_double;
  logic        out_valid, out_ready;
  logic [63:0] frac_bits, int_bits;

  modf_scoreboard split_sb;
  int          cycle_cnt;
  bit          calm;      // no idling on either side while set
  logic [63:0] dir_q[$];
  logic        dir_dbl_q[$];

  float_modf_split u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .value_bits_i   (value_bits),
    .is_double_i    (is_double),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .fraction_bits_o(frac_bits),
    .integral_bits_o(int_bits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample accepted items and results at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) split_sb.note_item(value_bits, is_double);
      if (out_valid && out_ready) split_sb.check_result(frac_bits, int_bits);
    end
  end

  // receiver: random stalls, driven on the falling edge
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 200000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_nan_mode(input bit val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    split_sb.nan_mode = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold one item on the input until accepted, with random gaps before it
  task automatic send_item(input logic [63:0] v, input logic dbl);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    value_bits <= v;
    is_double  <= dbl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (split_sb.exp_frac_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // random value biased toward the interesting exponent band
  function automatic logic [63:0] rand_value(logic dbl);
    logic [63:0] v;
    int          k;
    v = {$urandom, $urandom};
    k = $urandom_range(9);
    if (dbl) begin
      if (k < 6) v[62:52] = 11'(1023 + $urandom_range(56) - 3);
      else if (k == 6) v[62:52] = '1;
      else if (k == 7) v[62:52] = '0;
    end else begin
      if (k < 6) v[30:23] = 8'(127 + $urandom_range(27) - 3);
      else if (k == 6) v[30:23] = '1;
      else if (k == 7) v[30:23] = '0;
    end
    return v;
  endfunction

  task automatic random_phase(input int n);
    logic d;
    for (int i = 0; i < n; i++) begin
      d = 1'($urandom_range(1));
      send_item(rand_value(d), d);
    end
  endtask

  initial begin
    split_sb   = new();
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    in_valid   = 1'b0;
    value_bits = '0;
    is_double  = 1'b0;
    out_ready  = 1'b0;
    cycle_cnt  = 0;
    calm       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zeros, below one, 1.5, integral, large, inf, nan, subnormal
    dir_q = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FE0_0000_0000_0000,
              64'h3FF8_0000_0000_0000, 64'hC00C_0000_0000_0000, 64'h4000_0000_0000_0000,
              64'h4330_0000_0000_0001, 64'h432F_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
              64'hFFF8_0000_0000_0001, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_3FC0_0000, 64'h0000_0000_BF80_0001, 64'h0000_0000_4B00_0001,
              64'h0000_0000_4AFF_FFFF, 64'h0000_0000_7F80_0000, 64'h1234_5678_FFC0_0001,
              64'h0000_0000_0000_0001, 64'h0000_0000_3F00_0000, 64'h0000_0000_4040_0000};
    dir_dbl_q = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    foreach (dir_q[i]) send_item(dir_q[i], dir_dbl_q[i]);
    drain();

    // nan propagation on, then random traffic in both settings
    write_nan_mode(1'b1);
    foreach (dir_q[i]) send_item(dir_q[i], dir_dbl_q[i]);
    random_phase(250);
    calm = 1'b1;
    random_phase(150);  // back-to-back stretch
    calm = 1'b0;
    drain();
    write_nan_mode(1'b0);
    random_phase(430);
    drain();

    if (split_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== float_modf_split.f =====
+incdir+rtl/core
rtl/core/fmodf_pkg.sv
rtl/core/float_modf_split.sv
rtl/core/fmodf_checker.sv
tb/float_modf_split_tb.sv
